@@ sv/edt_pkg.sv @@
// Shared types and constants for the event deadline table.
// No dependencies; imported by edt_ram users and event_deadline_table.
package edt_pkg;

    localparam int NUM_EVENTS = 8;
    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 64;
    localparam int MASK_W     = 8;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 80;

    localparam logic [TIME_W-1:0] NONE_PENDING = {TIME_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_QUERY    = 2'd2,
        KIND_PROCESS  = 2'd3
    } kind_t;

endpackage

@@ sv/edt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module edt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/event_deadline_table.sv @@
// Event deadline table top level: slot deadlines in a RAM, sequencer for requests.
// Depends on edt_pkg and edt_ram.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tuser: kind; tdata: slot, when
//  m_      | out | m_tvalid / m_tready  | tdata: pending, fired_mask, next_trigger
//
// Schedule and cancel go straight to the done state, query reads its slot first,
// and the process step sweeps the deadline RAM one slot per cycle through its
// single read port. Reset (aresetn, synchronous) marks every slot not pending
// through per-slot valid bits; the RAM itself is never cleared.
// One request is in flight at a time; a finished result waits in the output
// register, and the next request is taken while it waits.
module event_deadline_table
    import edt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    input  logic [S_DATA_W-1:0]   s_tdata,   // [2:0] slot, [66:3] when, [71:67] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [0] pending, [8:1] fired_mask,
                                             // [72:9] next_trigger, [79:73] zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUERY,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [TIME_W-1:0]       when_reg, when_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [TIME_W-1:0]       least_reg, least_next;
    logic [NUM_EVENTS-1:0]   fired_reg, fired_next;
    logic [NUM_EVENTS-1:0]   valid_reg, valid_next;
    logic [TIME_W-1:0]       earliest_reg, earliest_next;
    logic                    res_pend_reg, res_pend_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    kind_t                   in_kind;
    logic [SLOT_W-1:0]       in_slot;
    logic [TIME_W-1:0]       in_when;
    logic                    accept;
    logic                    out_free;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [TIME_W-1:0]       ram_rdata;

    logic [TIME_W-1:0]       cur_dl;
    logic                    cur_pend;
    logic                    cur_fire;
    logic                    sweep_last;

    assign in_kind  = kind_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_when  = s_tdata[SLOT_W +: TIME_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ram_we = accept && (in_kind == KIND_SCHEDULE);

    always_comb begin
        if (state_reg == ST_SWEEP) begin
            ram_raddr = idx_reg + SLOT_W'(1);
        end else if (in_kind == KIND_PROCESS) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = in_slot;
        end
    end

    edt_ram #(
        .WIDTH(TIME_W),
        .DEPTH(NUM_EVENTS)
    ) u_dl_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(in_slot),
        .wdata(in_when),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // slot not valid reads as all ones
    assign cur_dl     = valid_reg[idx_reg] ? ram_rdata : NONE_PENDING;
    assign cur_pend   = (cur_dl != NONE_PENDING);
    assign cur_fire   = cur_pend && (when_reg >= cur_dl);
    assign sweep_last = (idx_reg == SLOT_W'(NUM_EVENTS - 1));

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        when_next     = when_reg;
        idx_next      = idx_reg;
        least_next    = least_reg;
        fired_next    = fired_reg;
        valid_next    = valid_reg;
        earliest_next = earliest_reg;
        res_pend_next = res_pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    slot_next     = in_slot;
                    when_next     = in_when;
                    idx_next      = '0;
                    least_next    = NONE_PENDING;
                    fired_next    = '0;
                    res_pend_next = 1'b0;
                    unique case (in_kind)
                        KIND_SCHEDULE: begin
                            valid_next[in_slot] = 1'b1;
                            if (in_when < earliest_reg) begin
                                earliest_next = in_when;
                            end
                            state_next = ST_DONE;
                        end
                        KIND_CANCEL: begin
                            valid_next[in_slot] = 1'b0;
                            state_next = ST_DONE;
                        end
                        KIND_QUERY:   state_next = ST_QUERY;
                        KIND_PROCESS: state_next = ST_SWEEP;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_QUERY: begin
                res_pend_next = valid_reg[slot_reg] && (ram_rdata != NONE_PENDING);
                state_next    = ST_DONE;
            end
            ST_SWEEP: begin
                if (cur_fire) begin
                    valid_next[idx_reg] = 1'b0;
                    fired_next[idx_reg] = 1'b1;
                end else if (cur_pend && (cur_dl < least_reg)) begin
                    least_next = cur_dl;
                end
                idx_next = idx_reg + SLOT_W'(1);
                if (sweep_last) begin
                    earliest_next = (cur_pend && !cur_fire && (cur_dl < least_reg))
                                    ? cur_dl : least_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W - 1 - MASK_W - TIME_W){1'b0}},
                                     earliest_reg, fired_reg[MASK_W-1:0], res_pend_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            earliest_reg <= NONE_PENDING;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            earliest_reg <= earliest_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        slot_reg     <= slot_next;
        when_reg     <= when_next;
        idx_reg      <= idx_next;
        least_reg    <= least_next;
        fired_reg    <= fired_next;
        res_pend_reg <= res_pend_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // one request in flight: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while another in flight");

    // a finished result holds back while the output register is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && m_tvalid_reg && !m_tready |=> (state_reg == ST_DONE))
        else $error("result overwrote a waiting output");

    // a fired slot is no longer pending after the sweep step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) && cur_fire |=> !valid_reg[$past(idx_reg)])
        else $error("fired slot left pending");
`endif

endmodule
